// ----- rtl/aob_pkg.sv -----
`default_nettype none

package aob_pkg;

    localparam int N_CH  = 3;   // blue, green, red lanes
    localparam int CH_W  = 8;
    localparam int REM_W = 24;  // color numerator, max 255*255*255
    localparam int DEN_W = 16;  // color denominator, max 255*255
    localparam int PRD_W = 16;  // 8x8 products

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [REM_W-1:0] t_rem;
    typedef logic [DEN_W-1:0] t_den;
    typedef logic [PRD_W-1:0] t_prd;

    // one pixel in flight through the divider cells
    typedef struct packed {
        logic [N_CH-1:0][REM_W-1:0] rem;
        logic [N_CH-1:0][CH_W-1:0]  quo;
        t_den                       den;
        t_chan                      alpha;
    } t_div;

endpackage

`default_nettype wire

// ----- rtl/aob_prep.sv -----
`default_nettype none

module aob_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_top_argb,
    input  wire logic [31:0]   i_bottom_argb,
    output logic               o_ready,
    output logic               o_valid,
    output aob_pkg::t_div      o_data,
    input  wire logic          i_ready
);
    import aob_pkg::*;

    // stage a: alpha products
    logic                        r_a_valid;
    t_chan                       r_a_at;
    t_prd                        r_a_w;
    logic [N_CH-1:0][PRD_W-1:0]  r_a_pt;
    logic [N_CH-1:0][CH_W-1:0]   r_a_cb;
    // stage b: numerators, denominator, alpha out
    logic                        r_b_valid;
    t_div                        r_b_data;

    logic   ready_a;
    logic   ready_b;
    t_chan  at;
    t_chan  ab;
    t_chan  inv;
    t_div   n_b_data;
    logic [PRD_W:0] w_round;

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

    assign at  = i_top_argb[31:24];
    assign ab  = i_bottom_argb[31:24];
    assign inv = 8'hff - at;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ready_a) r_a_valid <= i_valid;
            if (ready_b) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_at <= at;
            r_a_w  <= t_prd'(ab * inv);
            for (int c = 0; c < N_CH; c++) begin
                r_a_pt[c] <= t_prd'(i_top_argb[c*CH_W +: CH_W] * at);
                r_a_cb[c] <= i_bottom_argb[c*CH_W +: CH_W];
            end
        end
    end

    // floor(w/255) for w up to 255*255 is (w + 1 + (w >> 8)) >> 8
    assign w_round = {1'b0, r_a_w} + (PRD_W+1)'(1) + (PRD_W+1)'(r_a_w >> 8);

    always_comb begin
        n_b_data.quo   = '0;
        n_b_data.den   = t_den'({r_a_at, 8'h00}) - t_den'(r_a_at) + r_a_w;
        n_b_data.alpha = r_a_at + t_chan'(w_round >> 8);
        for (int c = 0; c < N_CH; c++) begin
            n_b_data.rem[c] = t_rem'({r_a_pt[c], 8'h00}) - t_rem'(r_a_pt[c])
                            + t_rem'(r_a_cb[c] * r_a_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b) r_b_data <= n_b_data;
    end

endmodule

`default_nettype wire

// ----- rtl/aob_div_cell.sv -----
`default_nettype none

module aob_div_cell #(
    parameter int BIT = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire aob_pkg::t_div i_data,
    output logic               o_ready,
    output logic               o_valid,
    output aob_pkg::t_div      o_data,
    input  wire logic          i_ready
);
    import aob_pkg::*;

    logic  r_valid;
    t_div  r_data;
    t_div  n_data;
    t_rem  den_sh;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign den_sh = t_rem'(i_data.den) << BIT;

    // restoring step: one quotient bit per lane
    always_comb begin
        n_data = i_data;
        for (int c = 0; c < N_CH; c++) begin
            if (i_data.rem[c] >= den_sh) begin
                n_data.rem[c]      = i_data.rem[c] - den_sh;
                n_data.quo[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_data <= n_data;
    end

endmodule

`default_nettype wire

// ----- rtl/alpha_over_blend_core.sv -----
`default_nettype none

// Porter-Duff over of two straight-alpha ARGB8888 pixels. One pixel pair is
// taken per clock while o_stall is low, and the result passes through these
// registers in order: prep stages a and b form the alpha products, the
// numerators and the shared denominator, a row of eight divider cells then
// retires one quotient bit per cell for all three color channels at once,
// and an output register holds the result. Every stage keeps its own valid
// bit, so a stall at the output only backs up as far as the pipeline is
// full. When both alphas are zero the result is all zeros.
module alpha_over_blend_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_top_argb,
    input  wire logic [31:0] i_bottom_argb,
    output logic             o_stall,
    output logic             o_valid,
    output logic [31:0]      o_blended_argb,
    input  wire logic        i_stall
);
    import aob_pkg::*;

    localparam int N_CELL = CH_W;

    logic               prep_ready;
    logic [N_CELL:0]    c_valid;
    logic [N_CELL:0]    c_ready;
    t_div               c_data [N_CELL+1];

    logic               r_out_valid;
    logic [31:0]        r_out_argb;
    logic               out_ready;
    t_div               last;

    assign o_stall = !prep_ready;

    aob_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_top_argb    (i_top_argb),
        .i_bottom_argb (i_bottom_argb),
        .o_ready       (prep_ready),
        .o_valid       (c_valid[0]),
        .o_data        (c_data[0]),
        .i_ready       (c_ready[0])
    );

    // cell k resolves quotient bit N_CELL-1-k
    for (genvar k = 0; k < N_CELL; k++) begin : g_cell
        aob_div_cell #(
            .BIT (N_CELL - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_data  (c_data[k]),
            .o_ready (c_ready[k]),
            .o_valid (c_valid[k+1]),
            .o_data  (c_data[k+1]),
            .i_ready (c_ready[k+1])
        );
    end

    assign last              = c_data[N_CELL];
    assign out_ready         = !r_out_valid || !i_stall;
    assign c_ready[N_CELL]   = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= c_valid[N_CELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            // zero denominator only when both alphas are zero
            if (last.den == '0) r_out_argb <= {last.alpha, 24'h000000};
            else                r_out_argb <= {last.alpha, last.quo};
        end
    end

    assign o_valid        = r_out_valid;
    assign o_blended_argb = r_out_argb;

    // an empty output register never pushes back on the input
    a_no_stall_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall
    ) else $error("input stalled with empty output register");

    // after the last cell every remainder is below the denominator
    a_rem_below_den: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (c_valid[N_CELL] && last.den != '0) |->
            (last.rem[0] < t_rem'(last.den) && last.rem[1] < t_rem'(last.den)
             && last.rem[2] < t_rem'(last.den))
    ) else $error("division did not converge");

    // zero denominator means both alphas were zero
    a_zero_den_alpha: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (c_valid[N_CELL] && last.den == '0) |-> (last.alpha == '0)
    ) else $error("zero denominator with nonzero alpha");

endmodule

`default_nettype wire

// ----- verif/tb_alpha_over_blend_core.sv -----
`timescale 1ns / 1ps

module tb_alpha_over_blend_core;

    typedef struct {
        logic [31:0] top;
        logic [31:0] bot;
    } t_pix_pair;

    localparam int N_RANDOM   = 1030;
    localparam int TAIL_ITEMS = 150;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_top_argb = '0;
    logic [31:0] i_bottom_argb = '0;
    logic        i_stall = 1'b0;
    wire logic   o_stall;
    wire logic   o_valid;
    wire logic [31:0] o_blended_argb;

    t_pix_pair   pix_queue[$];
    logic [31:0] blend_expect[$];

    int unsigned sent_cnt = 0;
    int unsigned cyc_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic        tail_phase = 1'b0;

    alpha_over_blend_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_top_argb     (i_top_argb),
        .i_bottom_argb  (i_bottom_argb),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_blended_argb (o_blended_argb),
        .i_stall        (i_stall)
    );

    // alpha-weighted average of one color lane, zero when both alphas are zero
    function automatic logic [7:0] blend_lane(logic [7:0] ct, logic [7:0] cb,
                                              logic [7:0] at, logic [7:0] ab);
        logic [31:0] inv;
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] q;
        inv = 32'd255 - 32'(at);
        num = 32'(ct) * 32'(at) * 32'd255 + 32'(cb) * 32'(ab) * inv;
        den = 32'd255 * 32'(at) + 32'(ab) * inv;
        if (den == 0) begin
            return 8'd0;
        end
        q = num / den;
        if (q > 32'd255) begin
            q = 32'd255;
        end
        return q[7:0];
    endfunction

    function automatic logic [31:0] over_composite(logic [31:0] top, logic [31:0] bot);
        logic [7:0]  at;
        logic [7:0]  ab;
        logic [31:0] ao;
        at = top[31:24];
        ab = bot[31:24];
        ao = 32'(at) + (32'(ab) * (32'd255 - 32'(at))) / 32'd255;
        if (ao > 32'd255) begin
            ao = 32'd255;
        end
        return {ao[7:0],
                blend_lane(top[23:16], bot[23:16], at, ab),
                blend_lane(top[15:8],  bot[15:8],  at, ab),
                blend_lane(top[7:0],   bot[7:0],   at, ab)};
    endfunction

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(1, 3));
            3:       return 8'($urandom_range(252, 254));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_pair(logic [31:0] top, logic [31:0] bot);
        t_pix_pair p;
        p.top = top;
        p.bot = bot;
        pix_queue.push_back(p);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
    end

    // source side: transfer bookkeeping, bursts of idle cycles, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                blend_expect.push_back(over_composite(i_top_argb, i_bottom_argb));
                sent_cnt <= sent_cnt + 1;
            end
            tail_phase <= (pix_queue.size() < TAIL_ITEMS);
            if (!i_valid || !o_stall) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 1'b0;
                end else if (!tail_phase && ((cyc_cnt / 128) % 3 != 0)
                             && $urandom_range(0, 6) == 0) begin
                    src_gap <= $urandom_range(0, 2);
                    i_valid <= 1'b0;
                end else if (pix_queue.size() != 0) begin
                    i_valid       <= 1'b1;
                    i_top_argb    <= pix_queue[0].top;
                    i_bottom_argb <= pix_queue[0].bot;
                    void'(pix_queue.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // sink side: compare each transfer, random stall bursts and one long hold-off
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (blend_expect.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10) begin
                        $display("unexpected result: blended_argb=%08h", o_blended_argb);
                    end
                end else begin
                    want = blend_expect.pop_front();
                    if (o_blended_argb !== want) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10) begin
                            $display("blended_argb: expected %08h, got %08h",
                                     want, o_blended_argb);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else if (!hold_done && sent_cnt >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN - 1;
                i_stall   <= 1'b1;
            end else if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                i_stall  <= 1'b1;
            end else if (!tail_phase && ((cyc_cnt / 96) % 3 != 1)
                         && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(0, 2);
                i_stall  <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        // both alphas zero
        add_pair(32'h00FF_FFFF, 32'h00FF_FFFF);
        add_pair(32'h0000_0000, 32'h0000_0000);
        // opaque top
        add_pair(32'hFF12_3456, 32'hFFAB_CDEF);
        add_pair(32'hFFFF_FFFF, 32'h0000_0000);
        add_pair(32'hFF00_0000, 32'hFFFF_FFFF);
        // transparent top over various bottoms
        add_pair(32'h00FF_FFFF, 32'hFF00_0000);
        add_pair(32'h0012_3456, 32'h0198_7654);
        add_pair(32'h00FF_FFFF, 32'hFFFF_FFFF);
        // alpha near the ends and in the middle
        add_pair(32'h01FF_FFFF, 32'hFF00_0000);
        add_pair(32'hFE00_0000, 32'h01FF_FFFF);
        add_pair(32'h01FF_00FF, 32'h0100_FF00);
        add_pair(32'h8080_8080, 32'h8080_8080);
        add_pair(32'h7FFF_FFFF, 32'h80FF_FFFF);
        add_pair(32'hAAAA_AAAA, 32'h5555_5555);
        add_pair(32'h5555_5555, 32'hAAAA_AAAA);
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_pair(32'h0100_0000, 32'h00FF_FFFF);
        add_pair(32'hFE12_3456, 32'hFEFE_DCBA);
        repeat (N_RANDOM) begin
            add_pair({pick_alpha(), 24'($urandom)}, {pick_alpha(), 24'($urandom)});
        end

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pix_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (blend_expect.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
